FILE: hw/rtl/set_symmetric_difference_macros.svh
// ----------------------------------------------------------------------------
// Set symmetric difference assertion macros
// Shared property wrappers for the checker of the set symmetric difference.
// ----------------------------------------------------------------------------
`ifndef SET_SYMMETRIC_DIFFERENCE_MACROS_SVH
`define SET_SYMMETRIC_DIFFERENCE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the clock edge after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Set symmetric difference package
// Shared constants, command codes and the structs that travel along the chain.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int MAX_ITEMS_DEF = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 6;
  localparam int IDX_W = CNT_W + 1;

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_FINISH   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             vld;
    logic             side;
    logic             hit;
    logic [VAL_W-1:0] val;
  } probe_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [VAL_W-1:0] wr_val;
    logic [CNT_W-1:0] a_cnt;
    logic [CNT_W-1:0] b_cnt;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/set_symmetric_difference.sv
// Appends are taken one beat per cycle while the input is not stalled and produce no result.
// A finish beat holds the input stalled through the injection state (one probe per entry),
// the drain state while the last probe walks the cell chain and the final state, longer
// if the result side stalls; results leave at up to one per cycle, when not stalled, as probes exit.
// Reset is synchronous: counts, the overflow flag and all valid bits clear; the
// list entries keep whatever they held.
// ----------------------------------------------------------------------------
// Set symmetric difference
// Loads two lists into a chain of cells and, on finish, streams each entry
// through the chain to find the values that occur in only one list.
// ----------------------------------------------------------------------------
module set_symmetric_difference #(
  parameter int MAX_ITEMS = ssd_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic signed [ssd_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ssd_pkg::VAL_W-1:0] out_value_res,
  output logic                             out_from_second,
  output logic                             out_last,
  output logic                             out_empty_res,
  output logic                             out_overflowed
);
  import ssd_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(MAX_ITEMS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INJECT,
    ST_DRAIN,
    ST_FINAL
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] a_cnt_r;
  logic [CNT_W-1:0] b_cnt_r;
  logic             ovf_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] drain_r;
  logic             hold_vld_r;
  logic             hold_side_r;
  logic [VAL_W-1:0] hold_val_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_side_r;
  logic             out_last_r;
  logic             out_empty_r;
  logic             out_ovf_r;

  logic             accept;
  logic             adv;
  logic [IDX_W-1:0] total;
  logic             rd_side;
  logic [IDX_W-1:0] rd_ent;
  logic [AW-1:0]    rd_addr;
  cell_ctl_t        ctl;
  probe_t           inject;
  probe_t           exit_probe;
  logic             emit;
  probe_t           chain [MAX_ITEMS+1];
  logic [VAL_W-1:0] a_vals [MAX_ITEMS];
  logic [VAL_W-1:0] b_vals [MAX_ITEMS];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign adv      = !out_valid_r || !out_stall;
  assign total    = {1'b0, a_cnt_r} + {1'b0, b_cnt_r};

  assign rd_side = (idx_r >= {1'b0, a_cnt_r});
  assign rd_ent  = rd_side ? (idx_r - {1'b0, a_cnt_r}) : idx_r;
  assign rd_addr = rd_ent[AW-1:0];

  assign ctl.wr_a   = accept && (in_cmd == CMD_APPEND_A) && (a_cnt_r < CAP);
  assign ctl.wr_b   = accept && (in_cmd == CMD_APPEND_B) && (b_cnt_r < CAP);
  assign ctl.wr_val = in_value;
  assign ctl.a_cnt  = a_cnt_r;
  assign ctl.b_cnt  = b_cnt_r;

  assign inject.vld  = (state_r == ST_INJECT);
  assign inject.side = rd_side;
  assign inject.hit  = 1'b0;
  assign inject.val  = rd_side ? b_vals[rd_addr] : a_vals[rd_addr];

  assign chain[0]   = inject;
  assign exit_probe = chain[MAX_ITEMS];
  assign emit       = adv && exit_probe.vld && !exit_probe.hit;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    ssd_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl    (ctl),
      .probe_i(chain[g]),
      .probe_o(chain[g+1]),
      .a_val_o(a_vals[g]),
      .b_val_o(b_vals[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      drain_r     <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= (emit && hold_vld_r) || (state_r == ST_FINAL);
      end
      if (emit) begin
        hold_vld_r  <= 1'b1;
        hold_val_r  <= exit_probe.val;
        hold_side_r <= exit_probe.side;
        if (hold_vld_r) begin
          out_val_r   <= hold_val_r;
          out_side_r  <= hold_side_r;
          out_last_r  <= 1'b0;
          out_empty_r <= 1'b0;
          out_ovf_r   <= ovf_r;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_cmd)
              CMD_APPEND_A: begin
                if (a_cnt_r < CAP) begin
                  a_cnt_r <= a_cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              CMD_APPEND_B: begin
                if (b_cnt_r < CAP) begin
                  b_cnt_r <= b_cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              CMD_FINISH: begin
                idx_r   <= '0;
                drain_r <= '0;
                state_r <= (total == '0) ? ST_DRAIN : ST_INJECT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_INJECT: begin
          if (adv) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == total - 1'b1) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (adv) begin
            drain_r <= drain_r + 1'b1;
            if (drain_r == DRAIN_LAST) begin
              state_r <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          if (adv) begin
            out_val_r   <= hold_vld_r ? hold_val_r : '0;
            out_side_r  <= hold_vld_r && hold_side_r;
            out_last_r  <= 1'b1;
            out_empty_r <= !hold_vld_r;
            out_ovf_r   <= ovf_r;
            hold_vld_r  <= 1'b0;
            a_cnt_r     <= '0;
            b_cnt_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_res   = out_val_r;
  assign out_from_second = out_side_r;
  assign out_last        = out_last_r;
  assign out_empty_res   = out_empty_r;
  assign out_overflowed  = out_ovf_r;

endmodule

FILE: hw/rtl/ssd_cell.sv
// ----------------------------------------------------------------------------
// Set symmetric difference cell
// Holds one entry of each list and compares the passing probe against the
// entry of the opposite list before handing it to the next cell.
// ----------------------------------------------------------------------------
module ssd_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  ssd_pkg::cell_ctl_t        ctl,
  input  ssd_pkg::probe_t           probe_i,
  output ssd_pkg::probe_t           probe_o,
  output logic [ssd_pkg::VAL_W-1:0] a_val_o,
  output logic [ssd_pkg::VAL_W-1:0] b_val_o
);
  import ssd_pkg::*;

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  logic [VAL_W-1:0] a_val_r;
  logic [VAL_W-1:0] b_val_r;
  probe_t           probe_r;
  logic             a_live;
  logic             b_live;
  logic             hit_here;

  assign a_live   = POS < ctl.a_cnt;
  assign b_live   = POS < ctl.b_cnt;
  assign hit_here = probe_i.side ? (a_live && (a_val_r == probe_i.val))
                                 : (b_live && (b_val_r == probe_i.val));

  always_ff @(posedge clk) begin
    if (ctl.wr_a && (ctl.a_cnt == POS)) begin
      a_val_r <= ctl.wr_val;
    end
    if (ctl.wr_b && (ctl.b_cnt == POS)) begin
      b_val_r <= ctl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else if (adv) begin
      probe_r.vld  <= probe_i.vld;
      probe_r.side <= probe_i.side;
      probe_r.val  <= probe_i.val;
      probe_r.hit  <= probe_i.hit || (probe_i.vld && hit_here);
    end
  end

  assign probe_o = probe_r;
  assign a_val_o = a_val_r;
  assign b_val_o = b_val_r;

endmodule

FILE: hw/rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// Set symmetric difference checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_symmetric_difference_macros.svh"

module ssd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [ssd_pkg::VAL_W-1:0] out_value_res,
  input logic                             out_from_second,
  input logic                             out_last,
  input logic                             out_empty_res,
  input logic                             out_overflowed
);

  `SSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_value_res) && $stable(out_from_second) && $stable(out_last)
      && $stable(out_empty_res) && $stable(out_overflowed),
    "Stalled result beat changed.")
  `SSD_ASSERT(a_empty_last, out_valid && out_empty_res |-> out_last,
    "Empty result is not the last beat.")
  `SSD_ASSERT(a_empty_zero, out_valid && out_empty_res |-> (out_value_res == '0) && !out_from_second,
    "Empty result carries a value.")
  `SSD_ASSERT(a_run_busy, out_valid && !out_last |-> in_stall,
    "Input taken while a run is still emitting.")

endmodule

bind set_symmetric_difference ssd_checker u_ssd_checker (.*);

FILE: sim/set_symmetric_difference_test.sv
// ----------------------------------------------------------------------------
// Set symmetric difference testbench
// Loads lists A and B beat by beat, finishes each run and checks every
// emitted element against a predictor or a table entry, with random sender
// gaps and receiver stalls. A short table of hand-picked beats runs first.
// ----------------------------------------------------------------------------
module set_symmetric_difference_test;

  import ssd_pkg::*;

  localparam int DEPTH = MAX_ITEMS_DEF;
  localparam int RANDOM_BEATS = 210;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             from_second;
    logic             last;
    logic             empty;
    logic             lost;
  } diff_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [VAL_W-1:0] value;
    logic [6:0]       repeats;
    logic             typed;
    diff_t            want;
  } plan_row_t;

  localparam diff_t EMPTY_CLEAN = '{32'h0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam diff_t EMPTY_LOST  = '{32'h0, 1'b0, 1'b1, 1'b1, 1'b1};

  localparam int PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b1, EMPTY_CLEAN},
    '{CMD_UNUSED,   32'hFFFF_FFFF, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h5A5A_5A5A, 7'd1,  1'b1, EMPTY_CLEAN},
    '{CMD_APPEND_A, 32'h8000_0000, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b1, '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{CMD_APPEND_B, 32'h7FFF_FFFF, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CMD_APPEND_A, 32'h0000_0005, 7'd1,  1'b0, '0},
    '{CMD_APPEND_A, 32'h0000_0005, 7'd1,  1'b0, '0},
    '{CMD_APPEND_A, 32'hFFFF_FFFF, 7'd1,  1'b0, '0},
    '{CMD_APPEND_B, 32'h0000_0000, 7'd1,  1'b0, '0},
    '{CMD_UNUSED,   32'h0000_0007, 7'd1,  1'b0, '0},
    '{CMD_APPEND_B, 32'hFFFF_FFFF, 7'd1,  1'b0, '0},
    '{CMD_APPEND_B, 32'h0000_0007, 7'd1,  1'b0, '0},
    '{CMD_APPEND_B, 32'h0000_0007, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b0, '0},
    '{CMD_APPEND_A, 32'h0000_0003, 7'd1,  1'b0, '0},
    '{CMD_APPEND_B, 32'h0000_0003, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b1, EMPTY_CLEAN},
    '{CMD_APPEND_A, 32'h1234_5678, 7'd33, 1'b0, '0},
    '{CMD_APPEND_B, 32'h1234_5678, 7'd1,  1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b1, EMPTY_LOST},
    '{CMD_FINISH,   32'hFFFF_FFFF, 7'd1,  1'b1, EMPTY_CLEAN},
    '{CMD_APPEND_B, 32'hA5A5_A5A5, 7'd33, 1'b0, '0},
    '{CMD_FINISH,   32'h0000_0000, 7'd1,  1'b0, '0}
  };

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_cmd = CMD_UNUSED;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_value_res;
  logic             out_from_second;
  logic             out_last;
  logic             out_empty_res;
  logic             out_overflowed;

  logic [VAL_W-1:0] list_a [DEPTH];
  logic [VAL_W-1:0] list_b [DEPTH];
  int unsigned      count_a = 0;
  int unsigned      count_b = 0;
  logic             append_lost = 1'b0;
  diff_t            run_diffs [$];
  diff_t            diff_queue [$];

  int unsigned      beats_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      mismatches = 0;
  int unsigned      stall_mode = 0;
  int unsigned      stall_span = 0;
  int unsigned      stall_tick = 0;

  set_symmetric_difference dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_cmd,
    .in_value,
    .out_valid,
    .out_stall,
    .out_value_res,
    .out_from_second,
    .out_last,
    .out_empty_res,
    .out_overflowed
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void predict_beat(input cmd_t cmd, input logic [VAL_W-1:0] value);
    logic  hit;
    diff_t d;
    run_diffs.delete();
    case (cmd)
      CMD_APPEND_A: begin
        if (count_a < DEPTH) begin
          list_a[count_a] = value;
          count_a++;
        end else begin
          append_lost = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (count_b < DEPTH) begin
          list_b[count_b] = value;
          count_b++;
        end else begin
          append_lost = 1'b1;
        end
      end
      CMD_FINISH: begin
        for (int i = 0; i < count_a; i++) begin
          hit = 1'b0;
          for (int j = 0; j < count_b; j++) begin
            if (list_b[j] == list_a[i]) hit = 1'b1;
          end
          if (!hit) run_diffs.push_back('{list_a[i], 1'b0, 1'b0, 1'b0, append_lost});
        end
        for (int i = 0; i < count_b; i++) begin
          hit = 1'b0;
          for (int j = 0; j < count_a; j++) begin
            if (list_a[j] == list_b[i]) hit = 1'b1;
          end
          if (!hit) run_diffs.push_back('{list_b[i], 1'b1, 1'b0, 1'b0, append_lost});
        end
        if (run_diffs.size() == 0) run_diffs.push_back('{32'h0, 1'b0, 1'b0, 1'b1, append_lost});
        d = run_diffs[run_diffs.size() - 1];
        d.last = 1'b1;
        run_diffs[run_diffs.size() - 1] = d;
        count_a = 0;
        count_b = 0;
        append_lost = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input cmd_t cmd, input logic [VAL_W-1:0] value, input logic typed,
                           input diff_t want);
    int unsigned idle;
    predict_beat(cmd, value);
    if (typed) begin
      diff_queue.push_back(want);
    end else begin
      foreach (run_diffs[i]) diff_queue.push_back(run_diffs[i]);
    end
    if (cmd != CMD_UNUSED) beats_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: idle = 0;
        9: idle = $urandom_range(4, 24);
        default: idle = $urandom_range(1, 3);
      endcase
      repeat (idle) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_cmd <= 2'($urandom_range(0, 3));
        in_value <= $urandom;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (diff_queue.size() != 0) @(posedge clk);
  endtask

  // One load of both lists followed by a finish. Values mostly come from a
  // small pool so that the lists overlap.
  task automatic random_run();
    logic [VAL_W-1:0] pool [4];
    logic [VAL_W-1:0] v;
    int unsigned      left_a;
    int unsigned      left_b;
    int unsigned      sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) begin
      left_a = $urandom_range(0, 6);
      left_b = $urandom_range(0, 6);
    end else if (sel < 18) begin
      left_a = $urandom_range(0, DEPTH);
      left_b = $urandom_range(0, DEPTH);
    end else begin
      left_a = $urandom_range(DEPTH - 2, DEPTH + 3);
      left_b = $urandom_range(0, DEPTH + 3);
    end
    foreach (pool[i]) begin
      case ($urandom_range(0, 5))
        0: pool[i] = 32'h8000_0000;
        1: pool[i] = 32'h7FFF_FFFF;
        2: pool[i] = 32'h0000_0000;
        default: pool[i] = $urandom;
      endcase
    end
    if ($urandom_range(0, 7) == 0) drain_results();
    while (left_a + left_b != 0) begin
      v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 3)] : $urandom;
      if ($urandom_range(0, 15) == 0) begin
        send_beat(CMD_UNUSED, v, 1'b0, '0);
      end else if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 0)) begin
        send_beat(CMD_APPEND_A, v, 1'b0, '0);
        left_a--;
      end else begin
        send_beat(CMD_APPEND_B, v, 1'b0, '0);
        left_b--;
      end
    end
    send_beat(CMD_FINISH, $urandom, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    diff_t got;
    diff_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_value_res, out_from_second, out_last, out_empty_res, out_overflowed};
      if (diff_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result value %h second %b last %b empty %b overflow %b",
                   got.value, got.from_second, got.last, got.empty, got.lost);
        end
      end else begin
        want = diff_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: expected value %h second %b last %b empty %b overflow %b",
                     want.value, want.from_second, want.last, want.empty, want.lost);
            $display("       got      value %h second %b last %b empty %b overflow %b",
                     got.value, got.from_second, got.last, got.empty, got.lost);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      repeat (PLAN[r].repeats) send_beat(PLAN[r].cmd, PLAN[r].value, PLAN[r].typed, PLAN[r].want);
    end
    drain_results();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) random_run();

    drain_results();
    repeat (2 * DEPTH + 16) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_cell.sv
hw/rtl/set_symmetric_difference.sv
hw/rtl/ssd_checker.sv
sim/set_symmetric_difference_test.sv
